// ===== src/pfns_pkg.sv =====
// ----------------------------------------------------------------------------
// pfns_pkg
// Shared constants, types and scaling factors for the palette frame scaler.
// ----------------------------------------------------------------------------
package pfns_pkg;

  // geometry
  localparam int SRC_WIDTH  = 256;
  localparam int SRC_HEIGHT = 240;
  localparam int OUT_SIZE   = 466;
  localparam int V_BORDER   = 35;

  // fixed field widths
  localparam int BYTE_W  = 8;
  localparam int COORD_W = 9;
  localparam int PIX_W   = 16;
  localparam int DATA_W  = 80;
  localparam int USER_W  = 2;

  typedef enum logic [1:0] {
    CMD_PAL_WR = 2'd0,
    CMD_SRC_WR = 2'd1,
    CMD_PIX_RD = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_PAL_WR   = 2'd0,
    OP_FRM_WR   = 2'd1,
    OP_PIX_RD   = 2'd2,
    OP_PIX_ZERO = 2'd3
  } op_t;

  localparam int COL_W       = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
  localparam int ROW_W       = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
  localparam int FRAME_DEPTH = SRC_WIDTH * SRC_HEIGHT;
  localparam int FRAME_AW    = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int ENT_AW      = (FRAME_AW > BYTE_W) ? FRAME_AW : BYTE_W;
  localparam int PAL_DEPTH   = 256;

  typedef struct packed {
    op_t                 op;
    logic [ENT_AW-1:0]   addr;
    logic [PIX_W-1:0]    data;
  } qent_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam bit BORDER_ALL  = (2 * V_BORDER >= OUT_SIZE);
  localparam int ACTIVE_ROWS = BORDER_ALL ? 1 : OUT_SIZE - 2 * V_BORDER;

  // n / d as (n * ceil(2^K / d)) >> K, with n < 2^N and d <= 2^D, K = N + D
  localparam int NX_W = ($clog2(OUT_SIZE * SRC_WIDTH) > 0) ? $clog2(OUT_SIZE * SRC_WIDTH) : 1;
  localparam int DX_W = $clog2(OUT_SIZE);
  localparam int K_X  = NX_W + DX_W;
  localparam int MX_W = K_X - DX_W + 2;
  localparam int PX_W = NX_W + MX_W;
  localparam logic [63:0] X_NUM = (64'd1 << K_X) + 64'(OUT_SIZE) - 64'd1;
  localparam logic [MX_W-1:0] M_X = MX_W'(X_NUM / 64'(OUT_SIZE));

  localparam int NY_W = ($clog2(ACTIVE_ROWS * SRC_HEIGHT) > 0) ?
                        $clog2(ACTIVE_ROWS * SRC_HEIGHT) : 1;
  localparam int DY_W = $clog2(ACTIVE_ROWS);
  localparam int K_Y  = NY_W + DY_W;
  localparam int MY_W = K_Y - DY_W + 2;
  localparam int PY_W = NY_W + MY_W;
  localparam logic [63:0] Y_NUM = (64'd1 << K_Y) + 64'(ACTIVE_ROWS) - 64'd1;
  localparam logic [MY_W-1:0] M_Y = MY_W'(Y_NUM / 64'(ACTIVE_ROWS));

endpackage

// ===== src/pfns_front.sv =====
// ----------------------------------------------------------------------------
// pfns_front
// Accepts requests, builds palette/frame writes and maps output pixels to
// frame addresses, then queues at most one operation per request.
// ----------------------------------------------------------------------------
module pfns_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pfns_pkg::cmd_t                  in_cmd,
  input  logic [pfns_pkg::BYTE_W-1:0]     in_pal_index,
  input  logic [pfns_pkg::BYTE_W-1:0]     in_red,
  input  logic [pfns_pkg::BYTE_W-1:0]     in_green,
  input  logic [pfns_pkg::BYTE_W-1:0]     in_blue,
  input  logic [pfns_pkg::BYTE_W-1:0]     in_src_col,
  input  logic [pfns_pkg::BYTE_W-1:0]     in_src_row,
  input  logic [pfns_pkg::BYTE_W-1:0]     in_color_index,
  input  logic [pfns_pkg::COORD_W-1:0]    in_out_col,
  input  logic [pfns_pkg::COORD_W-1:0]    in_out_row,
  output logic                            q_push,
  output pfns_pkg::qent_t                 q_ent,
  input  logic                            q_full
);
  import pfns_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_ADDR = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t           state_r, state_nxt;
  logic [NX_W-1:0]   nx_r, nx_nxt;
  logic [NY_W-1:0]   ny_r, ny_nxt;
  logic [PX_W-1:0]   px_r, px_nxt;
  logic [PY_W-1:0]   py_r, py_nxt;
  qent_t             ent_r, ent_nxt;
  logic              rd_zero;
  logic              src_ok;
  logic [PIX_W-1:0]  pal_color;

  // RGB565, bytes exchanged
  assign pal_color = {in_green[4:2], in_blue[7:3], in_red[7:3], in_green[7:5]};

  assign src_ok = (32'(in_src_col) < SRC_WIDTH) && (32'(in_src_row) < SRC_HEIGHT);

  assign rd_zero = BORDER_ALL
                || (32'(in_out_col) >= OUT_SIZE)
                || (32'(in_out_row) >= OUT_SIZE)
                || (32'(in_out_row) < V_BORDER)
                || (32'(in_out_row) >= OUT_SIZE - V_BORDER);

  assign in_ready = (state_r == F_IDLE);
  assign q_push   = (state_r == F_PUSH) && !q_full;
  assign q_ent    = ent_r;

  always_comb begin
    state_nxt = state_r;
    nx_nxt    = nx_r;
    ny_nxt    = ny_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    ent_nxt   = ent_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          nx_nxt = NX_W'(32'(in_out_col) * 32'(SRC_WIDTH));
          ny_nxt = NY_W'((32'(in_out_row) - 32'(V_BORDER)) * 32'(SRC_HEIGHT));
          case (in_cmd)
            CMD_PAL_WR: begin
              ent_nxt   = '{op: OP_PAL_WR, addr: ENT_AW'(in_pal_index), data: pal_color};
              state_nxt = F_PUSH;
            end
            CMD_SRC_WR: begin
              if (src_ok) begin
                ent_nxt = '{op: OP_FRM_WR,
                            addr: ENT_AW'(32'(in_src_row) * 32'(SRC_WIDTH)
                                          + 32'(in_src_col)),
                            data: PIX_W'(in_color_index)};
                state_nxt = F_PUSH;
              end
            end
            CMD_PIX_RD: begin
              if (rd_zero) begin
                ent_nxt   = '{op: OP_PIX_ZERO, addr: '0, data: '0};
                state_nxt = F_PUSH;
              end else begin
                state_nxt = F_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      F_MUL: begin
        px_nxt    = PX_W'(nx_r) * PX_W'(M_X);
        py_nxt    = PY_W'(ny_r) * PY_W'(M_Y);
        state_nxt = F_ADDR;
      end
      F_ADDR: begin
        // quotients stay below the source size, so no clamp is needed
        ent_nxt = '{op: OP_PIX_RD,
                    addr: ENT_AW'(32'(py_r[K_Y +: ROW_W]) * 32'(SRC_WIDTH)
                                  + 32'(px_r[K_X +: COL_W])),
                    data: '0};
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nx_r  <= nx_nxt;
    ny_r  <= ny_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    ent_r <= ent_nxt;
  end

endmodule

// ===== src/pfns_queue.sv =====
// ----------------------------------------------------------------------------
// pfns_queue
// Short FIFO of decoded operations between front and back.
// ----------------------------------------------------------------------------
module pfns_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pfns_pkg::qent_t  push_ent,
  output logic             full,
  input  logic             pop,
  output pfns_pkg::qent_t  head,
  output logic             empty
);
  import pfns_pkg::*;

  qent_t           ent_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]    cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == (QAW + 1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = ent_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

// ===== src/pfns_back.sv =====
// ----------------------------------------------------------------------------
// pfns_back
// Executes queued operations on the frame and palette memories and holds
// the result pixel in an output register.
// ----------------------------------------------------------------------------
module pfns_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  pfns_pkg::qent_t               q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pfns_pkg::PIX_W-1:0]    out_pixel
);
  import pfns_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_FRM  = 3'b010,
    B_PAL  = 3'b100
  } bstate_t;

  logic [BYTE_W-1:0] frame_mem [FRAME_DEPTH];
  logic [PIX_W-1:0]  pal_mem [PAL_DEPTH];

  bstate_t           state_r, state_nxt;
  logic [BYTE_W-1:0] frm_rd_r;
  logic [PIX_W-1:0]  pal_rd_r;
  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_pixel_r;
  logic              out_free;
  logic              frm_we, frm_re, pal_we, pal_re;
  logic              load_zero, load_pal;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign pal_re    = (state_r == B_FRM);

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    frm_we    = 1'b0;
    frm_re    = 1'b0;
    pal_we    = 1'b0;
    load_zero = 1'b0;
    load_pal  = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          case (q_head.op)
            OP_PAL_WR: begin
              pal_we = 1'b1;
              q_pop  = 1'b1;
            end
            OP_FRM_WR: begin
              frm_we = 1'b1;
              q_pop  = 1'b1;
            end
            OP_PIX_RD: begin
              if (out_free) begin
                frm_re    = 1'b1;
                q_pop     = 1'b1;
                state_nxt = B_FRM;
              end
            end
            OP_PIX_ZERO: begin
              if (out_free) begin
                load_zero = 1'b1;
                q_pop     = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      B_FRM: state_nxt = B_PAL;
      B_PAL: begin
        if (out_free) begin
          load_pal  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_zero || load_pal) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_zero) begin
      out_pixel_r <= '0;
    end else if (load_pal) begin
      out_pixel_r <= pal_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (frm_we) begin
      frame_mem[q_head.addr[FRAME_AW-1:0]] <= q_head.data[BYTE_W-1:0];
    end
    if (frm_re) begin
      frm_rd_r <= frame_mem[q_head.addr[FRAME_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[q_head.addr[BYTE_W-1:0]] <= q_head.data;
    end
    if (pal_re) begin
      pal_rd_r <= pal_mem[frm_rd_r];
    end
  end

endmodule

// ===== src/palette_frame_nearest_scaler.sv =====
// ----------------------------------------------------------------------------
// palette_frame_nearest_scaler
// Indexed frame with RGB565 palette, read out nearest-neighbor scaled to a
// square image with black top and bottom borders.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload
// in_     | in  | tuser: cmd; tdata: palette/pixel write or output pixel request
// out_    | out | tdata: pixel_out (byte-swapped RGB565)
//
// Writes and border reads pass the front through accept and queue push, active-area
// reads through accept, reciprocal multiply, address and queue push.
// The back performs writes from its idle state and reads as frame read,
// palette read and output load; a 4-entry queue separates the two.
// Reset is synchronous; memories are not cleared.
// A stalled output holds the back on reads; writes at the queue head still drain while the back is idle.
// ----------------------------------------------------------------------------
module palette_frame_nearest_scaler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [7:0] pal_index, [15:8] red, [23:16] green, [31:24] blue,
  // [39:32] src_col, [47:40] src_row, [55:48] color_index,
  // [64:56] out_col, [73:65] out_row, [79:74] zero
  input  logic [pfns_pkg::DATA_W-1:0]    in_tdata,
  // [1:0] cmd
  input  logic [pfns_pkg::USER_W-1:0]    in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] pixel_out
  output logic [pfns_pkg::PIX_W-1:0]     out_tdata
);
  import pfns_pkg::*;

  qent_t q_push_ent;
  qent_t q_head;
  logic  q_push, q_full, q_pop, q_empty;

  pfns_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_cmd         (cmd_t'(in_tuser)),
    .in_pal_index   (in_tdata[7:0]),
    .in_red         (in_tdata[15:8]),
    .in_green       (in_tdata[23:16]),
    .in_blue        (in_tdata[31:24]),
    .in_src_col     (in_tdata[39:32]),
    .in_src_row     (in_tdata[47:40]),
    .in_color_index (in_tdata[55:48]),
    .in_out_col     (in_tdata[64:56]),
    .in_out_row     (in_tdata[73:65]),
    .q_push         (q_push),
    .q_ent          (q_push_ent),
    .q_full         (q_full)
  );

  pfns_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_push_ent),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  pfns_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pixel (out_tdata)
  );

endmodule

// ===== src/pfns_checker.sv =====
// ----------------------------------------------------------------------------
// pfns_checker
// Port-level checks for the palette frame scaler, bound to the top level.
// ----------------------------------------------------------------------------
module pfns_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [pfns_pkg::DATA_W-1:0]    in_tdata,
  input logic [pfns_pkg::USER_W-1:0]    in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pfns_pkg::PIX_W-1:0]     out_tdata
);
  import pfns_pkg::*;

  // a result waiting for the sink stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // a pixel request keeps the front busy for at least the next cycle
  a_rd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_PIX_RD) |=> !in_tready)
    else $error("front ready right after a pixel request");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid set after reset");

  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("in_tready low after reset");

endmodule

bind palette_frame_nearest_scaler pfns_checker u_pfns_checker (.*);
